// ----- rtl/cbf_pkg.sv -----
// shared constants and types for the comment blanking filter
`default_nettype none

package cbf_pkg;

  localparam int unsigned BALANCE_BITS_DEF = 16;
  localparam int unsigned CLEAN_BAL_W      = 16;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_LINE      = 2'd1;
  localparam logic [1:0] MODE_DIRECTIVE = 2'd2;
  localparam logic [1:0] MODE_BLOCK     = 2'd3;

  typedef struct packed {
    logic [7:0] clean_byte;
    logic       blank_next;
    logic [1:0] mode;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/cbf_if.sv -----
// valid/ready channel interfaces for source bytes and cleaned bytes
`default_nettype none

interface cbf_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       src_end;

  modport source (output valid, output src_byte, output src_end, input ready);
  modport sink   (input valid, input src_byte, input src_end, output ready);
endinterface

interface cbf_clean_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  clean_byte;
  logic signed [15:0] brace_balance;
  logic               is_last;

  modport source (output valid, output clean_byte, output brace_balance, output is_last,
                  input ready);
  modport sink   (input valid, input clean_byte, input brace_balance, input is_last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/cbf_scan.sv -----
// byte classifier: blanking decision, mode change and brace count for one byte
`default_nettype none

module cbf_scan import cbf_pkg::*; #(
  parameter int unsigned BalanceBits = BALANCE_BITS_DEF
) (
  input  wire logic [1:0]             mode_i,
  input  wire logic [7:0]             cur_i,
  input  wire logic [7:0]             next_i,
  input  wire logic [BalanceBits-1:0] bal_i,
  output scan_res_t                   res_o,
  output logic      [BalanceBits-1:0] bal_o
);

  localparam logic [BalanceBits-1:0] BalMax = {1'b0, {(BalanceBits-1){1'b1}}};
  localparam logic [BalanceBits-1:0] BalMin = {1'b1, {(BalanceBits-1){1'b0}}};

  always_comb begin
    res_o.clean_byte = cur_i;
    res_o.blank_next = 1'b0;
    res_o.mode       = mode_i;
    unique case (mode_i)
      MODE_NORMAL: begin
        priority if (cur_i == CH_SLASH && next_i == CH_SLASH) begin
          res_o.clean_byte = CH_SPACE;
          res_o.blank_next = 1'b1;
          res_o.mode       = MODE_LINE;
        end else if (cur_i == CH_SLASH && next_i == CH_STAR) begin
          res_o.clean_byte = CH_SPACE;
          res_o.blank_next = 1'b1;
          res_o.mode       = MODE_BLOCK;
        end else if (cur_i == CH_HASH) begin
          res_o.clean_byte = CH_SPACE;
          res_o.mode       = MODE_DIRECTIVE;
        end else begin
          res_o.clean_byte = cur_i;
        end
      end
      MODE_LINE, MODE_DIRECTIVE: begin
        // escaped newline keeps the line going
        priority if (cur_i == CH_BSLASH && next_i == CH_NL) begin
          res_o.clean_byte = CH_SPACE;
          res_o.blank_next = 1'b1;
        end else if (cur_i == CH_NL) begin
          res_o.mode = MODE_NORMAL;
        end else begin
          res_o.clean_byte = CH_SPACE;
        end
      end
      MODE_BLOCK: begin
        res_o.clean_byte = CH_SPACE;
        if (cur_i == CH_STAR && next_i == CH_SLASH) begin
          res_o.blank_next = 1'b1;
          res_o.mode       = MODE_NORMAL;
        end
      end
      default: res_o.mode = MODE_NORMAL;
    endcase
  end

  // saturating brace count on the surviving byte
  always_comb begin
    bal_o = bal_i;
    if (res_o.clean_byte == CH_LBRACE && bal_i != BalMax) begin
      bal_o = bal_i + BalanceBits'(1);
    end else if (res_o.clean_byte == CH_RBRACE && bal_i != BalMin) begin
      bal_o = bal_i - BalanceBits'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/comment_blanking_filter_core.sv -----
// Comment blanking filter: takes C source one byte per beat and returns each byte once the
// byte after it has arrived, with comments and preprocessor lines turned into spaces and a
// saturating count of surviving braces alongside. A byte is registered on entry, classified
// against the next byte in one pass of short logic and written to a single result register,
// so it takes one byte per cycle while the output is not stalled; the final byte of a
// buffer (src_end set) yields two result beats through that register and so holds the input
// register for both. A byte's result beat is written to the result register in the step
// that holds its lookahead byte in the input register; the final byte's result comes from
// the tail pass against a zero lookahead. The first byte of a buffer gives no beat of its
// own.
`default_nettype none

module comment_blanking_filter_core import cbf_pkg::*; #(
  parameter int unsigned BalanceBits = BALANCE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cbf_src_if.sink     src_i,
  cbf_clean_if.source clean_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  // tail pass for the final byte of a buffer
  logic       tail_q;

  // filter state
  logic [1:0]             mode_q;
  logic [7:0]             held_byte_q;
  logic                   held_valid_q;
  logic                   forced_q;
  logic [BalanceBits-1:0] bal_q;

  // result register
  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic [CLEAN_BAL_W-1:0] out_bal_q;
  logic                   out_last_q;

  scan_res_t              scan_res;
  logic [BalanceBits-1:0] bal_next;
  logic [7:0]             cur_byte;
  logic [7:0]             look_byte;
  logic [CLEAN_BAL_W-1:0] bal_wide;

  logic can_emit, need_emit, step_fire, consume, emit;

  assign cur_byte  = forced_q ? CH_SPACE : held_byte_q;
  assign look_byte = tail_q ? CH_NUL : in_byte_q;

  cbf_scan #(
    .BalanceBits(BalanceBits)
  ) u_scan (
    .mode_i(mode_q),
    .cur_i (cur_byte),
    .next_i(look_byte),
    .bal_i (bal_q),
    .res_o (scan_res),
    .bal_o (bal_next)
  );

  generate
    if (BalanceBits >= CLEAN_BAL_W) begin : g_bal_trunc
      assign bal_wide = bal_next[CLEAN_BAL_W-1:0];
    end else begin : g_bal_sext
      assign bal_wide = {{(CLEAN_BAL_W-BalanceBits){bal_next[BalanceBits-1]}}, bal_next};
    end
  endgenerate

  assign can_emit  = !out_valid_q || clean_o.ready;
  assign need_emit = tail_q || held_valid_q;
  assign step_fire = in_valid_q && (!need_emit || can_emit);
  assign emit      = step_fire && need_emit;
  assign consume   = step_fire && (tail_q || !in_end_q);

  assign src_i.ready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= CH_NUL;
      in_end_q   <= 1'b0;
    end else if (src_i.ready) begin
      in_valid_q <= src_i.valid;
      in_byte_q  <= src_i.src_byte;
      in_end_q   <= src_i.src_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q       <= 1'b0;
      mode_q       <= MODE_NORMAL;
      held_byte_q  <= CH_NUL;
      held_valid_q <= 1'b0;
      forced_q     <= 1'b0;
      bal_q        <= '0;
    end else if (step_fire) begin
      if (tail_q) begin
        // final byte handled against a zero lookahead, then back to reset state
        tail_q       <= 1'b0;
        mode_q       <= MODE_NORMAL;
        held_byte_q  <= CH_NUL;
        held_valid_q <= 1'b0;
        forced_q     <= 1'b0;
        bal_q        <= '0;
      end else begin
        tail_q       <= in_end_q;
        held_byte_q  <= in_byte_q;
        held_valid_q <= 1'b1;
        if (held_valid_q) begin
          mode_q   <= scan_res.mode;
          bal_q    <= bal_next;
          forced_q <= scan_res.blank_next;
        end else begin
          forced_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (clean_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= scan_res.clean_byte;
      out_bal_q  <= bal_wide;
      out_last_q <= tail_q;
    end
  end

  assign clean_o.valid         = out_valid_q;
  assign clean_o.clean_byte    = out_byte_q;
  assign clean_o.brace_balance = out_bal_q;
  assign clean_o.is_last       = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/cbf_checker.sv -----
// port-level checks for the comment blanking filter, bound to the top level
`default_nettype none

module cbf_checker import cbf_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  clean_byte_i,
  input wire logic [15:0] brace_balance_i,
  input wire logic        is_last_i
);

  // no beat can come out of an empty pipe right after reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result beat right after reset");

  // a hash is always blanked or inside blanked text
  a_no_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> clean_byte_i != CH_HASH)
    else $error("hash byte passed through");

  // a new buffer starts its count from zero
  a_bal_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && is_last_i |=>
      !out_valid_i || brace_balance_i == 16'h0000 || brace_balance_i == 16'h0001 ||
      brace_balance_i == 16'hFFFF)
    else $error("brace count not restarted after last beat");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(clean_byte_i) && $stable(brace_balance_i) && $stable(is_last_i))
    else $error("stalled result beat changed");

endmodule

bind comment_blanking_filter_core cbf_checker u_cbf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (clean_o.valid),
  .out_ready_i    (clean_o.ready),
  .clean_byte_i   (clean_o.clean_byte),
  .brace_balance_i(clean_o.brace_balance),
  .is_last_i      (clean_o.is_last)
);

`default_nettype wire
